// ===== rtl/tcaas_pkg.sv =====
// Shared widths and constants for the two-channel averaging smoother.
package tcaas_pkg;

    localparam int SAMPLE_W  = 13;  // signed converter sample
    localparam int LEVEL_W   = 13;  // signed smoothed level / average
    localparam int SUPPLY_W  = 12;  // unsigned channel 0 level on the result beat
    localparam int SENSE_W   = 13;  // signed channel 1 level on the result beat
    localparam int S_TDATA_W = 16;  // sample padded to whole bytes
    localparam int M_TDATA_W = 32;  // both levels padded to whole bytes

endpackage

// ===== rtl/tcaas_accum.sv =====
// Per-channel frame accumulator with a registered frame-sum beat.
module tcaas_accum #(
    parameter int SAMPLES_PER_CHANNEL = 4,
    parameter int SUM_W               = 15
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [tcaas_pkg::SAMPLE_W-1:0] in_sample,
    output logic                                frm_valid,
    input  logic                                frm_ready,
    output logic signed [SUM_W-1:0]             frm_sum0,
    output logic signed [SUM_W-1:0]             frm_sum1
);
    import tcaas_pkg::*;

    localparam int FRAME_LEN = 2 * SAMPLES_PER_CHANNEL;
    localparam int POS_W     = (FRAME_LEN > 2) ? $clog2(FRAME_LEN) : 1;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

    logic [POS_W-1:0]        pos_reg, pos_next;
    logic signed [SUM_W-1:0] sum0_reg, sum0_next;
    logic signed [SUM_W-1:0] sum1_reg, sum1_next;
    logic                    frm_valid_reg, frm_valid_next;
    logic signed [SUM_W-1:0] frm_sum0_reg, frm_sum1_reg;
    logic signed [SUM_W-1:0] sample_ext;
    logic                    accept, last;

    assign in_ready   = !frm_valid_reg || frm_ready;
    assign accept     = in_valid && in_ready;
    assign last       = (pos_reg == LAST_POS);
    assign sample_ext = SUM_W'(in_sample);

    always_comb begin
        pos_next       = pos_reg;
        sum0_next      = sum0_reg;
        sum1_next      = sum1_reg;
        frm_valid_next = frm_valid_reg && !frm_ready;
        if (accept) begin
            if (last) begin
                // last beat of a frame is always channel 1
                pos_next       = '0;
                sum0_next      = '0;
                sum1_next      = '0;
                frm_valid_next = 1'b1;
            end else begin
                pos_next = pos_reg + POS_W'(1);
                if (pos_reg[0]) begin
                    sum1_next = sum1_reg + sample_ext;
                end else begin
                    sum0_next = sum0_reg + sample_ext;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            sum0_reg      <= '0;
            sum1_reg      <= '0;
            frm_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            sum0_reg      <= sum0_next;
            sum1_reg      <= sum1_next;
            frm_valid_reg <= frm_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && last) begin
            frm_sum0_reg <= sum0_reg;
            frm_sum1_reg <= sum1_reg + sample_ext;
        end
    end

    assign frm_valid = frm_valid_reg;
    assign frm_sum0  = frm_sum0_reg;
    assign frm_sum1  = frm_sum1_reg;

endmodule

// ===== rtl/tcaas_divide.sv =====
// Divide both frame sums by the samples per channel via reciprocal multiply.
module tcaas_divide #(
    parameter int SAMPLES_PER_CHANNEL = 4,
    parameter int SUM_W               = 15
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               frm_valid,
    output logic                               frm_ready,
    input  logic signed [SUM_W-1:0]            frm_sum0,
    input  logic signed [SUM_W-1:0]            frm_sum1,
    output logic                               quo_valid,
    input  logic                               quo_ready,
    output logic [tcaas_pkg::LEVEL_W-1:0]      quo_mag0,
    output logic [tcaas_pkg::LEVEL_W-1:0]      quo_mag1,
    output logic                               quo_neg0,
    output logic                               quo_neg1
);
    import tcaas_pkg::*;

    // magnitude < 2^SUM_W; exact floor for all such values with this shift
    localparam int L      = $clog2(SAMPLES_PER_CHANNEL);
    localparam int SHIFT  = SUM_W + L;
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << SHIFT) + SAMPLES_PER_CHANNEL - 1) / SAMPLES_PER_CHANNEL);

    logic [SUM_W-1:0]   mag0, mag1;
    logic [PROD_W-1:0]  prod0, prod1;
    logic               quo_valid_reg;
    logic [LEVEL_W-1:0] mag0_reg, mag1_reg;
    logic               neg0_reg, neg1_reg;
    logic               load;

    assign frm_ready = !quo_valid_reg || quo_ready;
    assign load      = frm_valid && frm_ready;

    assign mag0  = frm_sum0[SUM_W-1] ? SUM_W'(-frm_sum0) : SUM_W'(frm_sum0);
    assign mag1  = frm_sum1[SUM_W-1] ? SUM_W'(-frm_sum1) : SUM_W'(frm_sum1);
    assign prod0 = PROD_W'(mag0) * PROD_W'(RECIP);
    assign prod1 = PROD_W'(mag1) * PROD_W'(RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quo_valid_reg <= 1'b0;
        end else if (frm_ready) begin
            quo_valid_reg <= frm_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            mag0_reg <= prod0[SHIFT +: LEVEL_W];
            mag1_reg <= prod1[SHIFT +: LEVEL_W];
            neg0_reg <= frm_sum0[SUM_W-1];
            neg1_reg <= frm_sum1[SUM_W-1];
        end
    end

    assign quo_valid = quo_valid_reg;
    assign quo_mag0  = mag0_reg;
    assign quo_mag1  = mag1_reg;
    assign quo_neg0  = neg0_reg;
    assign quo_neg1  = neg1_reg;

endmodule

// ===== rtl/tcaas_smooth.sv =====
// Exponential smoothers for both channels, doubling as the result register.
module tcaas_smooth (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 quo_valid,
    output logic                                 quo_ready,
    input  logic [tcaas_pkg::LEVEL_W-1:0]        quo_mag0,
    input  logic [tcaas_pkg::LEVEL_W-1:0]        quo_mag1,
    input  logic                                 quo_neg0,
    input  logic                                 quo_neg1,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output logic signed [tcaas_pkg::LEVEL_W-1:0] level0,
    output logic signed [tcaas_pkg::LEVEL_W-1:0] level1
);
    import tcaas_pkg::*;

    localparam int ACC_W = LEVEL_W + 2;

    logic signed [LEVEL_W-1:0] avg0, avg1;
    logic signed [ACC_W-1:0]   acc0, acc1;
    logic signed [LEVEL_W-1:0] level0_reg, level0_next;
    logic signed [LEVEL_W-1:0] level1_reg, level1_next;
    logic                      seeded_reg;
    logic                      res_valid_reg;
    logic                      load;

    assign quo_ready = !res_valid_reg || res_ready;
    assign load      = quo_valid && quo_ready;

    // channel 0 clamps negatives to zero; channel 1 restores the sign
    assign avg0 = quo_neg0 ? '0 : $signed(quo_mag0);
    assign avg1 = quo_neg1 ? $signed(-quo_mag1) : $signed(quo_mag1);

    assign acc0 = ACC_W'(level0_reg) * ACC_W'(3) + ACC_W'(avg0);
    assign acc1 = ACC_W'(level1_reg) * ACC_W'(3) + ACC_W'(avg1);

    // dropping the two low bits of a signed value is a floor divide by four
    assign level0_next = seeded_reg ? $signed(acc0[ACC_W-1:2]) : avg0;
    assign level1_next = seeded_reg ? $signed(acc1[ACC_W-1:2]) : avg1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level0_reg    <= '0;
            level1_reg    <= '0;
            seeded_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (quo_ready) begin
                res_valid_reg <= quo_valid;
            end
            if (load) begin
                level0_reg <= level0_next;
                level1_reg <= level1_next;
                seeded_reg <= 1'b1;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign level0    = level0_reg;
    assign level1    = level1_reg;

endmodule

// ===== rtl/two_channel_adc_average_smoother.sv =====
// Top level of the two-channel frame averager with exponential smoothing.
//
//  channel | dir | beat contents (tdata, low bit first)      | when
//  --------+-----+--------------------------------------------+--------------------------
//  s_      | in  | [12:0] sample, [15:13] zero                | one per sample, ch0 then ch1
//  m_      | out | [11:0] supply_level, [24:12] sense_level,  | one per frame
//          |     | [31:25] zero                               |
//
// A sample beat can be taken every cycle while s_tready is high. The frame result
// passes from the accumulator's frame-sum register through the reciprocal multiply
// that divides both sums into the smoothers, whose registers are the result.
// aresetn (synchronous, active low) clears the sums, the frame position, the levels
// and the seeded flag. A stalled m_ beat holds; s_tready drops only while a frame
// result cannot move on through the stages behind the accumulator.
module two_channel_adc_average_smoother #(
    parameter int SAMPLES_PER_CHANNEL = 4
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tcaas_pkg::S_TDATA_W-1:0]  s_tdata,   // [12:0] sample
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tcaas_pkg::M_TDATA_W-1:0]  m_tdata    // [11:0] supply_level,
                                                         // [24:12] sense_level
);
    import tcaas_pkg::*;

    // sum of SAMPLES_PER_CHANNEL samples never leaves this width
    localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES_PER_CHANNEL);

    logic signed [SAMPLE_W-1:0] sample;
    logic                       frm_valid, frm_ready;
    logic signed [SUM_W-1:0]    frm_sum0, frm_sum1;
    logic                       quo_valid, quo_ready;
    logic [LEVEL_W-1:0]         quo_mag0, quo_mag1;
    logic                       quo_neg0, quo_neg1;
    logic signed [LEVEL_W-1:0]  level0, level1;

    assign sample = $signed(s_tdata[SAMPLE_W-1:0]);

    // accumulate samples and hand on one beat of sums per frame
    tcaas_accum #(
        .SAMPLES_PER_CHANNEL(SAMPLES_PER_CHANNEL),
        .SUM_W              (SUM_W)
    ) u_accum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_sample(sample),
        .frm_valid(frm_valid),
        .frm_ready(frm_ready),
        .frm_sum0 (frm_sum0),
        .frm_sum1 (frm_sum1)
    );

    // divide both sums, truncating toward zero
    tcaas_divide #(
        .SAMPLES_PER_CHANNEL(SAMPLES_PER_CHANNEL),
        .SUM_W              (SUM_W)
    ) u_divide (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .frm_valid(frm_valid),
        .frm_ready(frm_ready),
        .frm_sum0 (frm_sum0),
        .frm_sum1 (frm_sum1),
        .quo_valid(quo_valid),
        .quo_ready(quo_ready),
        .quo_mag0 (quo_mag0),
        .quo_mag1 (quo_mag1),
        .quo_neg0 (quo_neg0),
        .quo_neg1 (quo_neg1)
    );

    // smooth and hold the result beat
    tcaas_smooth u_smooth (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .quo_valid(quo_valid),
        .quo_ready(quo_ready),
        .quo_mag0 (quo_mag0),
        .quo_mag1 (quo_mag1),
        .quo_neg0 (quo_neg0),
        .quo_neg1 (quo_neg1),
        .res_valid(m_tvalid),
        .res_ready(m_tready),
        .level0   (level0),
        .level1   (level1)
    );

    // channel 0 level is never negative, so its low 12 bits carry it whole
    assign m_tdata = {(M_TDATA_W - SUPPLY_W - SENSE_W)'(0),
                      level1[SENSE_W-1:0],
                      level0[SUPPLY_W-1:0]};

endmodule

// ===== rtl/tcaas_checker.sv =====
// Port-level checks for the averaging smoother, bound to the top level.
module tcaas_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [tcaas_pkg::M_TDATA_W-1:0] m_tdata
);
    import tcaas_pkg::*;

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat valid after reset");

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // a fresh result is checked against its closing sample beat
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 3))
        else $error("result beat without a closing sample beat");

    // padding above the two levels stays zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:SUPPLY_W+SENSE_W] == '0)
        else $error("result padding not zero");

endmodule

bind two_channel_adc_average_smoother tcaas_checker u_tcaas_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
